// ===== hw/rtl/cxy_pkg.sv =====
`default_nettype none

package cxy_pkg;

	// quotient bits per channel, one divider cell each
	localparam int Q_BITS = 8;
	localparam int COORD_W = 16;

	// matrix magnitudes, seven decimal places
	localparam logic [31:0] M_RX = 32'd32404542;
	localparam logic [31:0] M_RY = 32'd15371385;
	localparam logic [31:0] M_RZ = 32'd4985314;
	localparam logic [31:0] M_GX = 32'd9692660;
	localparam logic [31:0] M_GY = 32'd18760633;
	localparam logic [31:0] M_GZ = 32'd415560;
	localparam logic [31:0] M_BX = 32'd556434;
	localparam logic [31:0] M_BY = 32'd2040259;
	localparam logic [31:0] M_BZ = 32'd10573110;

	localparam logic [63:0] DEC_SCALE = 64'd10000000;
	localparam logic [63:0] DEC_HALF = 64'd5000000;

	typedef enum logic [1:0] {
		SAT_ZERO = 2'd0,
		SAT_FULL = 2'd1,
		SAT_DIV  = 2'd2
	} sat_t;

	// magnitude rounded half away from zero, sign applied afterwards
	function automatic logic signed [63:0] coef_val(input logic [31:0] mag, input logic neg,
			input int frac);
		logic [63:0] fixed;
		fixed = ((64'(mag) << frac) + DEC_HALF) / DEC_SCALE;
		return neg ? -$signed(fixed) : $signed(fixed);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cxy_div_cell.sv =====
`default_nettype none

module cxy_div_cell
	import cxy_pkg::*;
#(
	parameter int D_W = 32
) (
	input  logic                    clk,
	input  logic [D_W+Q_BITS-1:0]   r_in,
	input  logic [D_W-1:0]          d_in,
	input  logic [Q_BITS-1:0]       q_in,
	input  sat_t                    mode_in,
	output logic [D_W+Q_BITS-1:0]   r_out,
	output logic [D_W-1:0]          d_out,
	output logic [Q_BITS-1:0]       q_out,
	output sat_t                    mode_out
);

	localparam int R_W = D_W + Q_BITS;

	logic [R_W-1:0] d_top;
	logic           take;
	logic [R_W-1:0] r_left;
	logic [R_W-1:0] r_q;
	logic [D_W-1:0] d_q;
	logic [Q_BITS-1:0] q_q;
	sat_t           mode_q;

	// divisor aligned to the top quotient bit; remainder stays below twice that
	assign d_top  = R_W'({d_in, {(Q_BITS-1){1'b0}}});
	assign take   = (r_in >= d_top);
	assign r_left = take ? (r_in - d_top) : r_in;

	always_ff @(posedge clk) begin
		r_q    <= r_left << 1;
		d_q    <= d_in;
		q_q    <= {q_in[Q_BITS-2:0], take};
		mode_q <= mode_in;
	end

	assign r_out    = r_q;
	assign d_out    = d_q;
	assign q_out    = q_q;
	assign mode_out = mode_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cxy_channel.sv =====
`default_nettype none

module cxy_channel
	import cxy_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter logic signed [FRAC_BITS+2:0] COEF_A = '0,
	parameter logic signed [FRAC_BITS+2:0] COEF_B = '0,
	parameter logic signed [FRAC_BITS+2:0] COEF_C = '0
) (
	input  logic               clk,
	input  logic [COORD_W-1:0] x_s1,
	input  logic [COORD_W-1:0] y_s1,
	output logic [Q_BITS-1:0]  chan
);

	localparam int CW  = FRAC_BITS + 3;
	localparam int PW  = CW + 18;
	localparam int NW  = PW + 2;
	localparam int D_W = COORD_W + FRAC_BITS;
	localparam int R_W = D_W + Q_BITS;

	logic signed [17:0] xs, ys, zs;
	logic signed [PW-1:0] pa_s2, pb_s2, pc_s2;
	logic [COORD_W-1:0]   y_s2, y_s3;
	logic signed [NW-1:0] n_s3;
	logic [D_W-1:0]       den;
	logic signed [NW-1:0] den_ext;
	logic [D_W-1:0]       n_lo;
	logic [R_W-1:0]       num;
	sat_t                 mode;
	logic [R_W-1:0]       num_s4;
	logic [D_W-1:0]       den_s4;
	sat_t                 mode_s4;

	logic [R_W-1:0]    r_c    [0:Q_BITS];
	logic [D_W-1:0]    d_c    [0:Q_BITS];
	logic [Q_BITS-1:0] q_c    [0:Q_BITS];
	sat_t              mode_c [0:Q_BITS];
	logic [Q_BITS-1:0] chan_q;

	assign xs = $signed({2'b00, x_s1});
	assign ys = $signed({2'b00, y_s1});
	// z term goes negative when x plus y passes full scale
	assign zs = 18'sd65535 - xs - ys;

	always_ff @(posedge clk) begin
		pa_s2 <= COEF_A * xs;
		pb_s2 <= COEF_B * ys;
		pc_s2 <= COEF_C * zs;
		y_s2  <= y_s1;
	end

	always_ff @(posedge clk) begin
		n_s3 <= NW'(pa_s2) + NW'(pb_s2) + NW'(pc_s2);
		y_s3 <= y_s2;
	end

	assign den     = {y_s3, {FRAC_BITS{1'b0}}};
	assign den_ext = $signed(NW'(den));
	assign n_lo    = n_s3[D_W-1:0];
	assign num     = (R_W'(n_lo) << Q_BITS) - R_W'(n_lo);

	always_comb begin
		if (y_s3 == '0 || n_s3 <= 0) begin
			mode = SAT_ZERO;
		end else if (n_s3 >= den_ext) begin
			mode = SAT_FULL;
		end else begin
			mode = SAT_DIV;
		end
	end

	always_ff @(posedge clk) begin
		num_s4  <= num;
		den_s4  <= den;
		mode_s4 <= mode;
	end

	assign r_c[0]    = num_s4;
	assign d_c[0]    = den_s4;
	assign mode_c[0] = mode_s4;
	assign q_c[0]    = '0;

	for (genvar k = 0; k < Q_BITS; k++) begin : g_cell
		cxy_div_cell #(
			.D_W(D_W)
		) u_cell (
			.clk      (clk),
			.r_in     (r_c[k]),
			.d_in     (d_c[k]),
			.q_in     (q_c[k]),
			.mode_in  (mode_c[k]),
			.r_out    (r_c[k+1]),
			.d_out    (d_c[k+1]),
			.q_out    (q_c[k+1]),
			.mode_out (mode_c[k+1])
		);
	end

	always_ff @(posedge clk) begin
		case (mode_c[Q_BITS])
			SAT_ZERO: chan_q <= '0;
			SAT_FULL: chan_q <= '1;
			SAT_DIV:  chan_q <= q_c[Q_BITS];
			default:  chan_q <= '0;
		endcase
	end

	assign chan = chan_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cie_xy_to_rgb8_converter.sv =====
`default_nettype none

// done is high when red, green and blue hold the result of a taken request
// throughput: one request per cycle; busy is always low, so start may stay high
// path: input register, three products, sum, range check, 8 divider cells
// (one quotient bit each), output register
// reset clears only the valid pipeline; the receiver cannot stall

module cie_xy_to_rgb8_converter
	import cxy_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [COORD_W-1:0] x_coord,
	input  logic [COORD_W-1:0] y_coord,
	output logic               done,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue
);

	localparam int CW = FRAC_BITS + 3;
	localparam int PIPE_DEPTH = 3 + Q_BITS + 1;

	localparam logic signed [CW-1:0] C_RX = CW'(coef_val(M_RX, 1'b0, FRAC_BITS));
	localparam logic signed [CW-1:0] C_RY = CW'(coef_val(M_RY, 1'b1, FRAC_BITS));
	localparam logic signed [CW-1:0] C_RZ = CW'(coef_val(M_RZ, 1'b1, FRAC_BITS));
	localparam logic signed [CW-1:0] C_GX = CW'(coef_val(M_GX, 1'b1, FRAC_BITS));
	localparam logic signed [CW-1:0] C_GY = CW'(coef_val(M_GY, 1'b0, FRAC_BITS));
	localparam logic signed [CW-1:0] C_GZ = CW'(coef_val(M_GZ, 1'b0, FRAC_BITS));
	localparam logic signed [CW-1:0] C_BX = CW'(coef_val(M_BX, 1'b0, FRAC_BITS));
	localparam logic signed [CW-1:0] C_BY = CW'(coef_val(M_BY, 1'b1, FRAC_BITS));
	localparam logic signed [CW-1:0] C_BZ = CW'(coef_val(M_BZ, 1'b0, FRAC_BITS));

	logic                  accept;
	logic                  vld_s1;
	logic [PIPE_DEPTH-1:0] vld_q;
	logic [COORD_W-1:0]    x_s1, y_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_q  <= '0;
		end else begin
			vld_s1 <= accept;
			vld_q  <= {vld_q[PIPE_DEPTH-2:0], vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= x_coord;
		y_s1 <= y_coord;
	end

	cxy_channel #(
		.FRAC_BITS (FRAC_BITS),
		.COEF_A    (C_RX),
		.COEF_B    (C_RY),
		.COEF_C    (C_RZ)
	) u_red (
		.clk  (clk),
		.x_s1 (x_s1),
		.y_s1 (y_s1),
		.chan (red)
	);

	cxy_channel #(
		.FRAC_BITS (FRAC_BITS),
		.COEF_A    (C_GX),
		.COEF_B    (C_GY),
		.COEF_C    (C_GZ)
	) u_green (
		.clk  (clk),
		.x_s1 (x_s1),
		.y_s1 (y_s1),
		.chan (green)
	);

	cxy_channel #(
		.FRAC_BITS (FRAC_BITS),
		.COEF_A    (C_BX),
		.COEF_B    (C_BY),
		.COEF_C    (C_BZ)
	) u_blue (
		.clk  (clk),
		.x_s1 (x_s1),
		.y_s1 (y_s1),
		.chan (blue)
	);

	assign done = vld_q[PIPE_DEPTH-1];

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top
	import cxy_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam int LATENCY = 13;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [COORD_W-1:0] x_coord = '0;
	logic [COORD_W-1:0] y_coord = '0;
	logic               busy;
	logic               done;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;

	rgb_t pending_rgb[$];
	int   errors = 0;
	int   n_requests = 0;
	int   n_checked = 0;
	int   n_saturated = 0;
	int   cycles = 0;
	int   idle_pct = 0;

	cie_xy_to_rgb8_converter #(.FRAC_BITS(FRAC)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycles,
				pending_rgb.size());
			$display("FAILURE");
			$finish;
		end
	end

	// magnitude to fixed point, half away from zero, then signed
	function automatic longint fixed_coef(longint mag, bit neg);
		longint f;
		f = ((mag << FRAC) + 64'd5000000) / 64'd10000000;
		return neg ? -f : f;
	endfunction

	function automatic logic [7:0] channel_level(longint a, longint b, longint c,
			longint xv, longint yv);
		longint n;
		longint den;
		n = a * xv + b * yv + c * (65535 - xv - yv);
		den = yv << FRAC;
		if (n <= 0)
			return 8'd0;
		if (n >= den)
			return 8'd255;
		return 8'((255 * n) / den);
	endfunction

	function automatic rgb_t xy_to_rgb(logic [15:0] x, logic [15:0] y);
		rgb_t   c;
		longint xv;
		longint yv;
		xv = longint'(x);
		yv = longint'(y);
		if (y == 16'd0)
			return '0;
		c.red   = channel_level(fixed_coef(32404542, 0), fixed_coef(15371385, 1),
			fixed_coef(4985314, 1), xv, yv);
		c.green = channel_level(fixed_coef(9692660, 1), fixed_coef(18760633, 0),
			fixed_coef(415560, 0), xv, yv);
		c.blue  = channel_level(fixed_coef(556434, 0), fixed_coef(2040259, 1),
			fixed_coef(10573110, 0), xv, yv);
		return c;
	endfunction

	// issue one request, idling first at the current rate
	task automatic send_xy(logic [15:0] x, logic [15:0] y);
		rgb_t c;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start   <= 1'b1;
		x_coord <= x;
		y_coord <= y;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		c = xy_to_rgb(x, y);
		pending_rgb.push_back(c);
		n_requests++;
		if (c.red inside {8'd0, 8'd255} || c.green inside {8'd0, 8'd255} ||
				c.blue inside {8'd0, 8'd255})
			n_saturated++;
	endtask

	always @(posedge clk) begin
		rgb_t want;
		if (arst_n && done) begin
			if (pending_rgb.size() == 0) begin
				$error("result with nothing pending: red %0d green %0d blue %0d",
					red, green, blue);
				errors++;
			end else begin
				want = pending_rgb.pop_front();
				n_checked++;
				if (red !== want.red) begin
					$error("red: expected %0d, got %0d", want.red, red);
					errors++;
				end
				if (green !== want.green) begin
					$error("green: expected %0d, got %0d", want.green, green);
					errors++;
				end
				if (blue !== want.blue) begin
					$error("blue: expected %0d, got %0d", want.blue, blue);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		logic [31:0] pairs[] = '{
			{16'd0, 16'd0}, {16'd65535, 16'd0}, {16'd0, 16'd65535},
			{16'd65535, 16'd65535}, {16'd0, 16'd1}, {16'd65535, 16'd1},
			{16'd1, 16'd1}, {16'd20493, 16'd21561}, {16'd41942, 16'd21627},
			{16'd19661, 16'd39321}, {16'd9830, 16'd3932}, {16'd40000, 16'd40000},
			{16'd100, 16'd10}, {16'd32768, 16'd32767}, {16'd32767, 16'd32768},
			{16'd21845, 16'd21845}, {16'd0, 16'd32768}, {16'd52428, 16'd13107},
			{16'd13107, 16'd52428}, {16'd1, 16'd65534}, {16'd65534, 16'd1},
			{16'hAAAA, 16'h5555}, {16'h5555, 16'hAAAA}
		};
		idle_pct = 0;
		foreach (pairs[i])
			send_xy(pairs[i][31:16], pairs[i][15:0]);
	endtask

	task automatic send_random_xy();
		logic [15:0] x;
		logic [15:0] y;
		case ($urandom_range(9))
			0, 1: begin
				x = 16'($urandom);
				y = 16'($urandom);
			end
			7: begin
				y = 16'($urandom_range(1, 64));
				x = 16'($urandom);
			end
			8: begin
				// x + y at or past the unit sum, z term zero or negative
				y = 16'($urandom_range(1, 65535));
				x = 16'($urandom_range(65535 - y, 65535));
			end
			9: begin
				x = 16'h1 << $urandom_range(15);
				y = ~(16'h1 << $urandom_range(15));
				if ($urandom_range(1)) begin
					x = ~x;
					y = ~y;
				end
			end
			default: begin
				// physically meaningful point
				y = 16'($urandom_range(1, 65535));
				x = 16'($urandom_range(0, 65535 - y));
			end
		endcase
		send_xy(x, y);
	endtask

	task automatic test_random(int count, int pct);
		idle_pct = pct;
		repeat (count)
			send_random_xy();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(410, 10);
		test_random(410, 59);
		test_random(410, 0);
		start <= 1'b0;
		while (pending_rgb.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		$display("sent %0d coordinate pairs (directed corners, gamut points, z below zero,",
			n_requests);
		$display("tiny y), checked %0d rgb results, %0d with a clipped channel",
			n_checked, n_saturated);
		if (errors == 0 && pending_rgb.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/cxy_pkg.sv
hw/rtl/cxy_div_cell.sv
hw/rtl/cxy_channel.sv
hw/rtl/cie_xy_to_rgb8_converter.sv
test/tb_top.sv
